// File: sv/arl_pkg.sv
`timescale 1ns / 1ps

package arl_pkg;

  localparam int unsigned WIN_LEN     = 22;
  localparam int unsigned FILL_WIDTH  = 5;
  localparam int unsigned RESULT_BITS = 32;

  localparam logic [7:0]  HDR_FIRST  = 8'h85;
  localparam logic [7:0]  HDR_SECOND = 8'h16;
  localparam logic [15:0] SUM_SEED   = {8'hA5, 8'h96};

  localparam logic [FILL_WIDTH-1:0] FILL_FULL = FILL_WIDTH'(WIN_LEN);

  typedef logic [WIN_LEN-1:0][7:0] window_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
  } request_t;

  typedef struct packed {
    logic [RESULT_BITS-1:0] record_offset;
    logic                   limit_reached;
  } result_t;

  typedef struct packed {
    logic valid;
    logic clear;
    logic full;
  } stage_t;

endpackage

// File: sv/arl_window.sv
`timescale 1ns / 1ps

module arl_window import arl_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    take_i,
  input  request_t                req_i,
  output stage_t                  stage_o,
  output window_t                 window_o,
  output logic [OFFSET_WIDTH-1:0] position_o
);

  window_t                 window_q, window_d;
  logic [FILL_WIDTH-1:0]   fill_q, fill_d;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic                    valid_q, valid_d;
  logic                    clear_q, clear_d;

  always_comb begin
    window_t                 base;
    logic [FILL_WIDTH-1:0]   fill_base;
    logic [OFFSET_WIDTH-1:0] pos_base;
    base      = req_i.buffer_start ? '0 : window_q;
    fill_base = req_i.buffer_start ? '0 : fill_q;
    pos_base  = req_i.buffer_start ? '0 : pos_q;
    window_d  = window_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    clear_d   = clear_q;
    valid_d   = take_i ? 1'b0 : valid_q;
    if (accept_i) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        window_d[i] = base[i+1];
      end
      window_d[WIN_LEN-1] = req_i.data_byte;
      fill_d  = (fill_base < FILL_FULL) ? fill_base + 1'b1 : fill_base;
      pos_d   = pos_base + 1'b1;
      clear_d = req_i.buffer_start;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
      pos_q    <= '0;
      valid_q  <= 1'b0;
      clear_q  <= 1'b0;
    end else begin
      window_q <= window_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      valid_q  <= valid_d;
      clear_q  <= clear_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.clear = clear_q;
  assign stage_o.full  = (fill_q == FILL_FULL);
  assign window_o      = window_q;
  assign position_o    = pos_q;

endmodule

// File: sv/arl_checksum.sv
`timescale 1ns / 1ps

module arl_checksum import arl_pkg::*; (
  input  window_t window_i,
  output logic    is_record_o
);

  logic [4:0][15:0] pair_sum;
  logic [15:0]      total;
  logic [15:0]      given;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      pair_sum[k] = {window_i[4*k+1], window_i[4*k]} + {window_i[4*k+3], window_i[4*k+2]};
    end
  end

  assign total = SUM_SEED + pair_sum[0] + pair_sum[1] + pair_sum[2]
               + pair_sum[3] + pair_sum[4];
  assign given = {window_i[WIN_LEN-1], window_i[WIN_LEN-2]};

  assign is_record_o = (window_i[0] == HDR_FIRST) && (window_i[1] == HDR_SECOND)
                    && (total == given);

endmodule

// File: sv/arl_report.sv
`timescale 1ns / 1ps

module arl_report import arl_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  stage_t                  stage_i,
  input  logic                    is_record_i,
  input  logic [OFFSET_WIDTH-1:0] position_i,
  input  logic [31:0]             max_matches_i,
  input  logic                    out_ready_i,
  output logic                    take_o,
  output logic                    out_valid_o,
  output result_t                 out_data_o
);

  logic [31:0]             count_q, count_d;
  logic                    done_q, done_d;
  logic                    out_valid_q, out_valid_d;
  result_t                 out_data_q, out_data_d;
  logic [OFFSET_WIDTH-1:0] offset;

  assign take_o = stage_i.valid && (!out_valid_q || out_ready_i);
  assign offset = position_i - OFFSET_WIDTH'(WIN_LEN - 1);

  always_comb begin
    logic [31:0] cnt;
    logic [31:0] cnt_next;
    logic        done;
    logic        hit;
    logic        lim;
    cnt         = stage_i.clear ? '0 : count_q;
    done        = stage_i.clear ? 1'b0 : done_q;
    hit         = stage_i.full && !done && is_record_i;
    cnt_next    = (cnt == '1) ? cnt : cnt + 1'b1;
    lim         = (max_matches_i != '0) && (cnt_next >= max_matches_i);
    count_d     = count_q;
    done_d      = done_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take_o) begin
      count_d     = cnt;
      done_d      = done;
      out_valid_d = 1'b0;
      if (hit) begin
        if ((max_matches_i != '0) && (cnt >= max_matches_i)) begin
          done_d = 1'b1;
        end else begin
          count_d                  = cnt_next;
          done_d                   = lim;
          out_valid_d              = 1'b1;
          out_data_d.record_offset = RESULT_BITS'(offset);
          out_data_d.limit_reached = lim;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sv/adv_record_locator.sv
`timescale 1ns / 1ps

// Record locator for a raw instrument byte stream.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one byte per
// request, with buffer_start marking the first byte of a new buffer.
// Output channel (out_valid_o / out_ready_i / out_data_o) carries one result
// per matched record up to the match limit: the 1-based offset of its first byte and a flag that
// the match limit was reached with it.
// cfg_we_i / cfg_wdata_i write max_matches (0 means no limit); write it only
// while the block is idle.
// Throughput: one byte per clock while the output is not stalled. The window
// shift register takes the byte when it is accepted; the checksum adder tree
// and match bookkeeping load the output register when the window stage is
// taken, so a result passes the window register and then the output register.
// When the receiver stalls, one result waits in the output register and one
// more byte is held in the window stage; in_ready_o then drops until the
// result is taken.
// Reset clears the window, fill count, position, match count, the limit
// state, the output valid and max_matches.

module adv_record_locator import arl_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  request_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_data_o,
  input  logic     cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0]             max_q;
  stage_t                  stage;
  window_t                 window;
  logic [OFFSET_WIDTH-1:0] position;
  logic                    is_record;
  logic                    take;
  logic                    accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !stage.valid || take;
  assign accept     = in_valid_i && in_ready_o;

  arl_window #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .take_i     (take),
    .req_i      (in_data_i),
    .stage_o    (stage),
    .window_o   (window),
    .position_o (position)
  );

  arl_checksum u_checksum (
    .window_i    (window),
    .is_record_o (is_record)
  );

  arl_report #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_report (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .is_record_i   (is_record),
    .position_i    (position),
    .max_matches_i (max_q),
    .out_ready_i   (out_ready_i),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o)
  );

endmodule
